@@ rtl/cwb_pkg.sv @@
// ----------------------------------------------------------------------------
// cwb_pkg: shared definitions for the complex weighted beamformer
// Holds the sizes of the block, the item kind codes and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cwb_pkg;

	// Sizes of the beamformer.
	localparam int NUM_BEAMS    = 8;
	localparam int NUM_CHANNELS = 16;
	localparam int SAMPLE_BITS  = 16;

	// Field widths on the stream ports.
	localparam int BEAM_W   = 3;
	localparam int CHAN_W   = 4;
	localparam int VALUE_W  = 16;
	localparam int RESULT_W = 39;

	// Internal widths.
	localparam int ADDR_W      = BEAM_W + CHAN_W;
	localparam int RAM_DEPTH   = 2 ** ADDR_W;
	localparam int WEIGHT_W    = 2 * SAMPLE_BITS;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int SUM_W       = PROD_W + 1;
	localparam int ACC_W       = RESULT_W;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 88;

	// Item kind codes carried in the input tuser.
	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              weight_we;
		logic              latch_sample;
		logic              issue;
		logic              load_out;
		logic [BEAM_W-1:0] beam;
		logic              last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic chan_ok;
		logic last_chan;
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

@@ rtl/complex_weighted_beamformer_unit.sv @@
// ----------------------------------------------------------------------------
// complex_weighted_beamformer_unit: narrowband complex-weight beamformer
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: kind; tdata: beam, channel, real, imag
//   m_axis    out        tdata: beam, real sum, imag sum; tlast: last beam
//
// A weight write is stored as it is accepted. A sample is accepted, then
// weight reads for every beam go through the single multiply-accumulate
// lane and the pipeline drains; s_axis_tready is low until that is done.
// The last channel then emits one result per beam, one result per cycle
// while m_axis_tready is high. arst_n clears the controller, pipeline
// valids and accumulators; the weight store is undefined until written.
// A stalled output holds the emission.
// ----------------------------------------------------------------------------
module complex_weighted_beamformer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// Fields from bit 0: beam_index[3], channel_index[4], value_real[16],
	// value_imag[16], zero pad[1].
	input  logic [cwb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Fields from bit 0: kind[1].
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// Fields from bit 0: out_beam[3], beam_real[39], beam_imag[39],
	// zero pad[7].
	output logic [cwb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tlast
);

	cwb_pkg::cmd_t    cmd;
	cwb_pkg::status_t sts;

	// Controller.
	cwb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_kind (s_axis_tuser),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath.
	cwb_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

@@ rtl/cwb_ram.sv @@
// ----------------------------------------------------------------------------
// cwb_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cwb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/cwb_ctrl.sv @@
// ----------------------------------------------------------------------------
// cwb_ctrl: beamformer controller
// Accepts input transactions, steps the beam counter through the
// multiply-accumulate pass and then through the result emission.
// ----------------------------------------------------------------------------
module cwb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	output logic             in_ready,
	input  cwb_pkg::status_t sts,
	output cwb_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [cwb_pkg::BEAM_W-1:0] BEAM_LAST =
		cwb_pkg::BEAM_W'(cwb_pkg::NUM_BEAMS - 1);

	logic [1:0]                 state_q, state_d;
	logic [cwb_pkg::BEAM_W-1:0] cnt_q, cnt_d;
	logic                       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state, counter and commands.
	always_comb begin
		state_d          = state_q;
		cnt_d            = cnt_q;
		cmd              = '0;
		cmd.beam         = cnt_q;
		cmd.last         = (cnt_q == BEAM_LAST);
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					if (in_kind == cwb_pkg::KIND_WEIGHT) begin
						cmd.weight_we = 1'b1;
					end else if (sts.chan_ok) begin
						cmd.latch_sample = 1'b1;
						state_d          = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (cnt_q == BEAM_LAST) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = sts.last_chan ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (cnt_q == BEAM_LAST) begin
						cnt_d   = '0;
						state_d = ST_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// A blocked output stage holds the emission where it is.
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !sts.out_free) |=> (state_q == ST_EMIT && $stable(cnt_q)))
		else $error("emission advanced while the output stage was blocked");

	// The last beam issue always hands over to the drain phase.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == BEAM_LAST) |=> (state_q == ST_DRAIN))
		else $error("multiply-accumulate pass did not end after the last beam");

endmodule

@@ rtl/cwb_datapath.sv @@
// ----------------------------------------------------------------------------
// cwb_datapath: beamformer datapath
// Weight store, complex multiplier pipeline, per-beam accumulators and the
// output register.
// ----------------------------------------------------------------------------
module cwb_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [cwb_pkg::IN_TDATA_W-1:0]      in_data,
	input  cwb_pkg::cmd_t                       cmd,
	output cwb_pkg::status_t                    sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cwb_pkg::OUT_TDATA_W-1:0]     out_data,
	output logic                                out_last
);

	localparam int SB = cwb_pkg::SAMPLE_BITS;
	localparam int BW = cwb_pkg::BEAM_W;
	localparam int CW = cwb_pkg::CHAN_W;
	localparam int VW = cwb_pkg::VALUE_W;
	localparam int RE_LO = BW + CW;
	localparam int IM_LO = RE_LO + VW;
	localparam int PAD_W = cwb_pkg::OUT_TDATA_W - BW - 2 * cwb_pkg::RESULT_W;

	// Input fields.
	logic [BW-1:0]        in_beam;
	logic [CW-1:0]        in_chan;
	logic signed [SB-1:0] in_re, in_im;

	assign in_beam = in_data[BW-1:0];
	assign in_chan = in_data[RE_LO-1:BW];
	assign in_re   = in_data[RE_LO+SB-1:RE_LO];
	assign in_im   = in_data[IM_LO+SB-1:IM_LO];

	logic beam_ok, chan_ok;
	assign beam_ok = ({1'b0, in_beam} < (BW+1)'(cwb_pkg::NUM_BEAMS));
	assign chan_ok = ({1'b0, in_chan} < (CW+1)'(cwb_pkg::NUM_CHANNELS));

	// Sample registers.
	logic [CW-1:0]        chan_q;
	logic signed [SB-1:0] xr_q, xi_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_sample) begin
			chan_q <= in_chan;
			xr_q   <= in_re;
			xi_q   <= in_im;
		end
	end

	// Weight store.
	logic [cwb_pkg::WEIGHT_W-1:0] rdata;

	cwb_ram #(
		.WIDTH(cwb_pkg::WEIGHT_W),
		.DEPTH(cwb_pkg::RAM_DEPTH)
	) u_weights (
		.clk  (clk),
		.we   (cmd.weight_we && beam_ok && chan_ok),
		.waddr({in_beam, in_chan}),
		.wdata({in_im, in_re}),
		.raddr({cmd.beam, chan_q}),
		.rdata(rdata)
	);

	// Pipeline valid bits.
	logic v_s1, v_s2, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Beam tags travel alongside the pipeline.
	logic [BW-1:0] beam_s1, beam_s2, beam_s3;

	always_ff @(posedge clk) begin
		beam_s1 <= cmd.beam;
		beam_s2 <= beam_s1;
		beam_s3 <= beam_s2;
	end

	// Stage 2: the four partial products.
	logic signed [SB-1:0]                wr, wi;
	logic signed [cwb_pkg::PROD_W-1:0]   rr_s2, ii_s2, ri_s2, ir_s2;

	assign wr = rdata[SB-1:0];
	assign wi = rdata[2*SB-1:SB];

	always_ff @(posedge clk) begin
		rr_s2 <= xr_q * wr;
		ii_s2 <= xi_q * wi;
		ri_s2 <= xr_q * wi;
		ir_s2 <= xi_q * wr;
	end

	// Stage 3: real and imaginary parts of the product.
	logic signed [cwb_pkg::SUM_W-1:0] pr_s3, pi_s3;

	always_ff @(posedge clk) begin
		pr_s3 <= cwb_pkg::SUM_W'(rr_s2) - cwb_pkg::SUM_W'(ii_s2);
		pi_s3 <= cwb_pkg::SUM_W'(ri_s2) + cwb_pkg::SUM_W'(ir_s2);
	end

	// Accumulators share one read index between update and emission.
	logic [cwb_pkg::ACC_W-1:0] acc_re_q [cwb_pkg::NUM_BEAMS];
	logic [cwb_pkg::ACC_W-1:0] acc_im_q [cwb_pkg::NUM_BEAMS];
	logic [BW-1:0]             acc_idx;
	logic [cwb_pkg::ACC_W-1:0] acc_re_rd, acc_im_rd, base_re, base_im;
	logic [cwb_pkg::ACC_W-1:0] add_re, add_im;
	logic                      clear;

	assign acc_idx   = v_s3 ? beam_s3 : cmd.beam;
	assign acc_re_rd = acc_re_q[acc_idx];
	assign acc_im_rd = acc_im_q[acc_idx];
	assign clear     = (chan_q == '0);
	assign base_re   = clear ? '0 : acc_re_rd;
	assign base_im   = clear ? '0 : acc_im_rd;
	assign add_re    = {{(cwb_pkg::ACC_W-cwb_pkg::SUM_W){pr_s3[cwb_pkg::SUM_W-1]}}, pr_s3};
	assign add_im    = {{(cwb_pkg::ACC_W-cwb_pkg::SUM_W){pi_s3[cwb_pkg::SUM_W-1]}}, pi_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < cwb_pkg::NUM_BEAMS; b++) begin
				acc_re_q[b] <= '0;
				acc_im_q[b] <= '0;
			end
		end else if (v_s3) begin
			acc_re_q[beam_s3] <= base_re + add_re;
			acc_im_q[beam_s3] <= base_im + add_im;
		end
	end

	// Output register.
	logic                      out_valid_q;
	logic [BW-1:0]             out_beam_q;
	logic [cwb_pkg::ACC_W-1:0] out_re_q, out_im_q;
	logic                      out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_beam_q <= cmd.beam;
			out_re_q   <= acc_re_rd;
			out_im_q   <= acc_im_rd;
			out_last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{PAD_W{1'b0}}, out_im_q, out_re_q, out_beam_q};
	assign out_last  = out_last_q;

	// Status to the controller.
	assign sts.chan_ok   = chan_ok;
	assign sts.last_chan = (chan_q == CW'(cwb_pkg::NUM_CHANNELS - 1));
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.out_free  = !out_valid_q || out_ready;

	// Emission reads the accumulators only once the pipeline has drained.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(v_s1 || v_s2 || v_s3))
		else $error("result loaded while accumulation was still in flight");

	// Every issued read reaches the accumulator stage.
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> ##1 v_s3)
		else $error("multiply-accumulate pipeline lost an entry");

endmodule
